/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SIRDX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SIRDX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sirdx_pkg.sv */
// Shared types and constants of the signed integer to radix digits unit.
// No dependencies; imported by the divider, the top level and the checker.
package sirdx_pkg;

   localparam int SYMBOL_BITS = 8;
   localparam int DIGIT_BITS  = 4;
   localparam int RADIX_BITS  = 5;
   localparam int MAX_SYMBOLS = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [SYMBOL_BITS-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYMBOL_BITS-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      REG_BASE_LEN   = 2'd0,
      REG_ALPHA_LOW  = 2'd1,
      REG_ALPHA_HIGH = 2'd2
   } reg_index_type;

   // Divider status: done pulses for one cycle with the digit valid.
   typedef struct packed {
      logic                  done;
      logic [DIGIT_BITS-1:0] digit;
   } div_status_type;

endpackage

/* rtl/core/sirdx_req_if.sv */
// Request channel: valid/ready handshake carrying one signed value.
// No dependencies.
interface sirdx_req_if #(
   parameter int VALUE_BITS = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

/* rtl/core/sirdx_rsp_if.sv */
// Response channel: valid/ready handshake carrying one symbol byte and a last flag.
// No dependencies.
interface sirdx_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink (input valid, input symbol, input last, output ready);
endinterface

/* rtl/core/sirdx_divider.sv */
// Iterative divide of a magnitude by the radix using a stored reciprocal.
// Depends on sirdx_pkg. One slice multiply per cycle, then a correction step.
module sirdx_divider
   import sirdx_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [RADIX_BITS-1:0] divisor,
   input  logic [VALUE_BITS-1:0] recip,
   output logic [VALUE_BITS-1:0] quotient,
   output div_status_type        status
);

   localparam int SLICE_BITS = 16;
   localparam int SLICES     = (VALUE_BITS + SLICE_BITS - 1) / SLICE_BITS;
   localparam int PAD_BITS   = SLICES * SLICE_BITS;
   localparam int ACC_BITS   = PAD_BITS + VALUE_BITS;
   localparam int SC_BITS    = (SLICES > 1) ? $clog2(SLICES) : 1;

   logic                  mul_ff, mul_in;
   logic                  fix_ff, fix_in;
   logic                  done_ff, done_in;
   logic [SC_BITS-1:0]    slice_ff, slice_in;
   logic [PAD_BITS-1:0]   shift_ff, shift_in;
   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [DIGIT_BITS-1:0] digit_ff, digit_in;

   logic [SLICE_BITS+VALUE_BITS-1:0] prod;
   logic [VALUE_BITS-1:0]            q_est;
   logic [VALUE_BITS+RADIX_BITS-1:0] q_times_b;
   logic [RADIX_BITS:0]              rem_est;
   logic [RADIX_BITS:0]              rem_fix;
   logic                             rem_ge;

   // Reciprocal is floor(2^VALUE_BITS / b): the estimate is the true
   // quotient or one below it, so one compare-subtract corrects it.
   always_comb begin
      prod      = shift_ff[PAD_BITS-1 -: SLICE_BITS] * recip;
      q_est     = acc_ff[VALUE_BITS +: VALUE_BITS];
      q_times_b = q_est * divisor;
      rem_est   = dvd_ff[RADIX_BITS:0] - q_times_b[RADIX_BITS:0];
      rem_ge    = rem_est >= {1'b0, divisor};
      rem_fix   = rem_est - {1'b0, divisor};
   end

   always_comb begin
      mul_in   = mul_ff;
      fix_in   = 1'b0;
      done_in  = 1'b0;
      slice_in = slice_ff;
      shift_in = shift_ff;
      dvd_in   = dvd_ff;
      acc_in   = acc_ff;
      quot_in  = quot_ff;
      digit_in = digit_ff;
      if (start) begin
         mul_in   = 1'b1;
         slice_in = SC_BITS'(SLICES - 1);
         shift_in = PAD_BITS'(dividend);
         dvd_in   = dividend;
         acc_in   = '0;
      end else if (mul_ff) begin
         acc_in   = (acc_ff << SLICE_BITS) + ACC_BITS'(prod);
         shift_in = shift_ff << SLICE_BITS;
         slice_in = slice_ff - 1'b1;
         if (slice_ff == '0) begin
            mul_in = 1'b0;
            fix_in = 1'b1;
         end
      end else if (fix_ff) begin
         done_in  = 1'b1;
         quot_in  = q_est + VALUE_BITS'(rem_ge);
         digit_in = rem_ge ? rem_fix[DIGIT_BITS-1:0] : rem_est[DIGIT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      slice_ff <= slice_in;
      shift_ff <= shift_in;
      dvd_ff   <= dvd_in;
      acc_ff   <= acc_in;
      quot_ff  <= quot_in;
      digit_ff <= digit_in;
   end

   assign quotient     = quot_ff;
   assign status.done  = done_ff;
   assign status.digit = digit_ff;

endmodule

/* rtl/core/signed_integer_to_radix_digits_unit.sv */
// Flow: a check state, which drops the request if the alphabet is unusable, then one divide
// per digit in the shared divider; a minus sign goes out first for a negative value, then the
// digits most significant first, one symbol per cycle while the response side keeps up.
// A new request is taken only in idle, once the last symbol of the previous one is loaded.
// Reset: synchronous, active high; clears control state and the three registers to zero.
module signed_integer_to_radix_digits_unit
   import sirdx_pkg::*;
#(
   parameter int MAX_BASE   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   sirdx_req_if.sink                req_if,
   sirdx_rsp_if.source              rsp_if,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int CW = $clog2(VALUE_BITS + 1);
   localparam int AW = $clog2(VALUE_BITS);
   localparam logic [VALUE_BITS:0] ONE = {1'b1, {VALUE_BITS{1'b0}}};
   localparam logic [VALUE_BITS-1:0] RECIP_TAB [32] = '{
      2:  VALUE_BITS'(ONE / 2),  3:  VALUE_BITS'(ONE / 3),  4:  VALUE_BITS'(ONE / 4),
      5:  VALUE_BITS'(ONE / 5),  6:  VALUE_BITS'(ONE / 6),  7:  VALUE_BITS'(ONE / 7),
      8:  VALUE_BITS'(ONE / 8),  9:  VALUE_BITS'(ONE / 9),  10: VALUE_BITS'(ONE / 10),
      11: VALUE_BITS'(ONE / 11), 12: VALUE_BITS'(ONE / 12), 13: VALUE_BITS'(ONE / 13),
      14: VALUE_BITS'(ONE / 14), 15: VALUE_BITS'(ONE / 15), 16: VALUE_BITS'(ONE / 16),
      default: '0
   };

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [RADIX_BITS-1:0]    base_len_ff;
   logic [CSR_DATA_BITS-1:0] alpha_low_ff;
   logic [CSR_DATA_BITS-1:0] alpha_high_ff;
   logic                     ok_ff, ok_in;
   logic [VALUE_BITS-1:0]    recip_ff;

   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic                  sign_pend_ff, sign_pend_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [DIGIT_BITS-1:0] rd_data_ff;
   logic                  rd_last_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_BITS-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [DIGIT_BITS-1:0] digit_store [VALUE_BITS];

   logic [SYMBOL_BITS-1:0] sym [MAX_SYMBOLS];
   logic                   csr_write;
   logic [1:0]             csr_index;
   logic                   req_accept;
   logic [VALUE_BITS-1:0]  in_raw;
   logic [VALUE_BITS-1:0]  in_mag;
   logic                   div_start;
   logic [VALUE_BITS-1:0]  div_dividend;
   logic [VALUE_BITS-1:0]  div_quot;
   div_status_type         div_status;
   logic                   div_finish;
   logic                   out_free;
   logic                   load_sign;
   logic                   load_digit;
   logic                   rd_issue;
   logic [CW-1:0]          rem_m1;

   // ---- configuration port ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:3];

   always_comb begin
      unique case (csr_index)
         REG_BASE_LEN:   csr_prdata = CSR_DATA_BITS'(base_len_ff);
         REG_ALPHA_LOW:  csr_prdata = alpha_low_ff;
         REG_ALPHA_HIGH: csr_prdata = alpha_high_ff;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff   <= '0;
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BASE_LEN:   base_len_ff   <= csr_pwdata[RADIX_BITS-1:0];
            REG_ALPHA_LOW:  alpha_low_ff  <= csr_pwdata;
            REG_ALPHA_HIGH: alpha_high_ff <= csr_pwdata;
            default:        ;
         endcase
      end
   end

   // ---- alphabet check and reciprocal, recomputed every cycle ----
   always_comb begin
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         sym[i] = (i < 8) ? alpha_low_ff[(i % 8) * 8 +: 8] : alpha_high_ff[(i % 8) * 8 +: 8];
      end
   end

   always_comb begin
      ok_in = (base_len_ff >= RADIX_BITS'(2)) && (base_len_ff <= RADIX_BITS'(MAX_BASE));
      for (int i = 0; i < MAX_BASE; i++) begin
         if (RADIX_BITS'(i) < base_len_ff) begin
            if (sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS) begin
               ok_in = 1'b0;
            end
            for (int j = i + 1; j < MAX_BASE; j++) begin
               if (RADIX_BITS'(j) < base_len_ff && sym[i] == sym[j]) begin
                  ok_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff <= 1'b0;
      end else begin
         ok_ff <= ok_in;
      end
      recip_ff <= RECIP_TAB[base_len_ff];
   end

   // ---- shared divider ----
   sirdx_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (base_len_ff),
      .recip    (recip_ff),
      .quotient (div_quot),
      .status   (div_status)
   );

   // ---- request side ----
   assign req_if.ready = (state_ff == ST_IDLE) && !reset;
   assign req_accept   = req_if.valid && req_if.ready;
   assign in_raw       = req_if.value;
   assign in_mag       = in_raw[VALUE_BITS-1] ? (~in_raw + VALUE_BITS'(1)) : in_raw;
   assign div_finish   = (div_quot == '0) || (count_ff == CW'(VALUE_BITS - 1));

   // ---- symbol output: sign first, then digits read most significant first ----
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign load_sign  = (state_ff == ST_EMIT) && sign_pend_ff && out_free;
   assign load_digit = rd_pend_ff && !sign_pend_ff && out_free;
   assign rd_issue   = (state_ff == ST_EMIT) && (rem_ff != '0) && (!rd_pend_ff || load_digit);
   assign rem_m1     = rem_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      sign_pend_in = sign_pend_ff;
      div_start    = 1'b0;
      div_dividend = mag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               neg_in   = in_raw[VALUE_BITS-1];
               mag_in   = in_mag;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (ok_ff) begin
               div_start = 1'b1;
               count_in  = '0;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               count_in = count_ff + 1'b1;
               if (div_finish) begin
                  rem_in       = count_ff + 1'b1;
                  sign_pend_in = neg_ff;
                  state_in     = ST_EMIT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_quot;
               end
            end
         end
         ST_EMIT: begin
            if (load_sign) begin
               sign_pend_in = 1'b0;
            end
            if (rd_issue) begin
               rem_in = rem_m1;
            end
            if (rem_ff == '0 && !rd_pend_ff && !sign_pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rd_pend_in = rd_pend_ff;
      if (rd_issue) begin
         rd_pend_in = 1'b1;
      end else if (load_digit) begin
         rd_pend_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      priority if (load_sign) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = CHAR_MINUS;
         rsp_last_in   = 1'b0;
      end else if (load_digit) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = sym[rd_data_ff];
         rsp_last_in   = rd_last_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // digit store: written as digits come out, read back in reverse order
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIVIDE && div_status.done) begin
         digit_store[count_ff[AW-1:0]] <= div_status.digit;
      end
      if (rd_issue) begin
         rd_data_ff <= digit_store[rem_m1[AW-1:0]];
         rd_last_ff <= (rem_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         sign_pend_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         sign_pend_ff <= sign_pend_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.symbol = rsp_symbol_ff;
   assign rsp_if.last   = rsp_last_ff;

endmodule

/* rtl/core/sirdx_checker.sv */
// Port-level checks for the signed integer to radix digits unit, bound to its top level.
// Depends on sirdx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sirdx_checker
   import sirdx_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SYMBOL_BITS-1:0] rsp_symbol,
   input logic                   rsp_last
);

   // one request at a time: taking one closes the request side
   `SIRDX_ASSERT_NEXT(a_req_closes, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")

   `SIRDX_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_symbol) && $stable(rsp_last), "stalled response changed")

   // the sign always has digits after it
   `SIRDX_ASSERT_IMPL(a_sign_not_last, clock, reset, rsp_valid && rsp_symbol == CHAR_MINUS, !rsp_last, "sign flagged last")

   `SIRDX_ASSERT_IMPL(a_no_plus, clock, reset, rsp_valid, rsp_symbol != CHAR_PLUS, "plus symbol emitted")

endmodule

bind signed_integer_to_radix_digits_unit sirdx_checker u_sirdx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_symbol (rsp_if.symbol),
   .rsp_last   (rsp_if.last)
);

/* tb/radix_symbol_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the radix digits unit: follows CSR writes, predicts the symbols of each
// request and compares every response beat. Depends on sirdx_pkg and both channel interfaces.
module radix_symbol_checker
   import sirdx_pkg::*;
#(
   parameter int MAX_BASE   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   sirdx_req_if                     req_mon,
   sirdx_rsp_if                     rsp_mon,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       symbols_pending,
   output int                       mismatch_count
);

   typedef struct packed {
      logic [SYMBOL_BITS-1:0] symbol;
      logic                   last;
   } symbol_beat_type;

   logic [RADIX_BITS-1:0]      radix_reg;
   logic [2*CSR_DATA_BITS-1:0] alphabet_reg;   // symbol i sits in byte i
   symbol_beat_type            expected_symbols[$];

   function automatic logic [SYMBOL_BITS-1:0] symbol_at(int index);
      return alphabet_reg[index*SYMBOL_BITS +: SYMBOL_BITS];
   endfunction

   function automatic bit alphabet_usable();
      logic [SYMBOL_BITS-1:0] sym;
      if (radix_reg < 2 || radix_reg > MAX_BASE) return 1'b0;
      for (int i = 0; i < radix_reg; i++) begin
         sym = symbol_at(i);
         if (sym == CHAR_PLUS || sym == CHAR_MINUS) return 1'b0;
         for (int j = i + 1; j < radix_reg; j++)
            if (symbol_at(j) == sym) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_symbols(logic [VALUE_BITS-1:0] value);
      logic                  negative;
      logic [VALUE_BITS-1:0] magnitude;
      logic [VALUE_BITS-1:0] radix;
      logic [DIGIT_BITS-1:0] digits[VALUE_BITS];
      int                    count;
      if (!alphabet_usable()) return;
      negative  = value[VALUE_BITS-1];
      // unsigned magnitude, so the most negative value comes out right
      magnitude = negative ? -value : value;
      radix     = VALUE_BITS'(radix_reg);
      count     = 0;
      do begin
         digits[count] = DIGIT_BITS'(magnitude % radix);
         count++;
         magnitude = magnitude / radix;
      end while (magnitude != 0 && count < VALUE_BITS);
      if (negative) expected_symbols.push_back('{symbol: CHAR_MINUS, last: 1'b0});
      for (int k = count - 1; k >= 0; k--)
         expected_symbols.push_back('{symbol: symbol_at(digits[k]), last: (k == 0)});
   endfunction

   initial mismatch_count = 0;

   always @(posedge clock) begin
      symbol_beat_type got;
      symbol_beat_type want;
      if (reset) begin
         radix_reg    = '0;
         alphabet_reg = '0;
         expected_symbols.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{symbol: rsp_mon.symbol, last: rsp_mon.last};
            if (expected_symbols.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected symbol, expected none, got %02h last %0b",
                        $time, got.symbol, got.last);
            end else begin
               want = expected_symbols.pop_front();
               if (got.symbol !== want.symbol) begin
                  mismatch_count++;
                  $display("%0t: symbol mismatch, expected %02h, got %02h",
                           $time, want.symbol, got.symbol);
               end
               if (got.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: last mismatch, expected %0b, got %0b",
                           $time, want.last, got.last);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            case (csr_paddr[CSR_ADDR_BITS-1:3])
               REG_BASE_LEN:   radix_reg = csr_pwdata[RADIX_BITS-1:0];
               REG_ALPHA_LOW:  alphabet_reg[CSR_DATA_BITS-1:0] = csr_pwdata;
               REG_ALPHA_HIGH: alphabet_reg[2*CSR_DATA_BITS-1:CSR_DATA_BITS] = csr_pwdata;
               default: ;
            endcase
         if (req_mon.valid && req_mon.ready) predict_symbols(req_mon.value);
      end
      symbols_pending = expected_symbols.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the radix digits testbench: clock, reset, CSR and request stimulus, verdict.
// Depends on sirdx_pkg, both channel interfaces, the unit and radix_symbol_checker.
module testbench;
   import sirdx_pkg::*;

   localparam int VALUE_BITS    = 32;
   localparam int MAX_BASE      = 16;
   localparam int ALPHABET_BITS = 2 * CSR_DATA_BITS;
   localparam int RANDOM_ITEMS  = 420;
   localparam int DRAIN_CYCLES  = 200;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   typedef enum int {
      ALPHA_GOOD, ALPHA_BAD_RADIX, ALPHA_HAS_PLUS, ALPHA_HAS_MINUS, ALPHA_REPEAT
   } alphabet_kind_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       symbols_pending;
   int                       mismatch_count;
   int                       cycle_count = 0;
   bit                       sender_steady = 1'b0;

   sirdx_req_if #(.VALUE_BITS(VALUE_BITS)) req_if ();
   sirdx_rsp_if rsp_if ();

   signed_integer_to_radix_digits_unit #(
      .MAX_BASE  (MAX_BASE),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   radix_symbol_checker #(
      .MAX_BASE  (MAX_BASE),
      .VALUE_BITS(VALUE_BITS)
   ) symbol_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .symbols_pending(symbols_pending),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 92) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // response side backpressure, with stretches of none
   initial begin
      int  stall_left;
      bit  ready_steady;
      stall_left   = 0;
      ready_steady = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 299) == 0) ready_steady = !ready_steady;
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!ready_steady && $urandom_range(0, 99) < 30) stall_left = idle_length();
         end
      end
   end

   task automatic send_value(logic [VALUE_BITS-1:0] value);
      int gap;
      gap = (sender_steady || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= value;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // drop valid, wait for every expected symbol, then let the unit settle
   task automatic wait_idle(int settle);
      req_if.valid <= 1'b0;
      do @(negedge clock); while (symbols_pending != 0);
      @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int radix, logic [ALPHABET_BITS-1:0] symbols);
      logic [CSR_DATA_BITS-1:0] data;
      data = {$urandom, $urandom};
      data[RADIX_BITS-1:0] = RADIX_BITS'(radix);   // upper bits are don't-care
      csr_write(REG_ALPHA_LOW, symbols[CSR_DATA_BITS-1:0]);
      csr_write(REG_BASE_LEN, data);
      csr_write(REG_ALPHA_HIGH, symbols[ALPHABET_BITS-1:CSR_DATA_BITS]);
      if ($urandom_range(0, 3) == 0) csr_write(REG_UNMAPPED, {$urandom, $urandom});
   endtask

   // distinct legal symbols in the used slots, anything at all above them
   function automatic logic [ALPHABET_BITS-1:0] make_alphabet(int used,
                                                              alphabet_kind_type kind);
      logic [ALPHABET_BITS-1:0] symbols;
      logic [SYMBOL_BITS-1:0]   sym;
      bit                       clash;
      int                       a;
      int                       b;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (i >= used) begin
            case ($urandom_range(0, 5))
               0:       symbols[i*8 +: 8] = CHAR_PLUS;
               1:       symbols[i*8 +: 8] = CHAR_MINUS;
               2:       symbols[i*8 +: 8] = symbols[7:0];
               default: symbols[i*8 +: 8] = SYMBOL_BITS'($urandom);
            endcase
         end else begin
            do begin
               sym   = SYMBOL_BITS'($urandom);
               clash = (sym == CHAR_PLUS || sym == CHAR_MINUS);
               for (int j = 0; j < i; j++)
                  if (symbols[j*8 +: 8] == sym) clash = 1'b1;
            end while (clash);
            symbols[i*8 +: 8] = sym;
         end
      end
      a = $urandom_range(0, used - 1);
      case (kind)
         ALPHA_HAS_PLUS:  symbols[a*8 +: 8] = CHAR_PLUS;
         ALPHA_HAS_MINUS: symbols[a*8 +: 8] = CHAR_MINUS;
         ALPHA_REPEAT: begin
            b = (a + $urandom_range(1, used - 1)) % used;
            symbols[b*8 +: 8] = symbols[a*8 +: 8];
         end
         default: ;
      endcase
      return symbols;
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_value(int radix);
      logic [VALUE_BITS-1:0] v;
      bit                    flip;
      flip = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            v    = $urandom;
            flip = 1'b0;
         end
         4, 5: v = $urandom >> $urandom_range(1, 31);
         6:    v = $urandom_range(0, radix * radix);
         7: begin
            // near a power of the radix, where the digit count steps
            v = 1;
            repeat ($urandom_range(1, 31)) v = v * radix;
            v = v + $urandom_range(0, 2) - 1;
         end
         8: begin
            flip = 1'b0;
            case ($urandom_range(0, 5))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7fff_ffff;
               2:       v = 32'h0000_0000;
               3:       v = 32'hffff_ffff;
               4:       v = 32'h0000_0001;
               default: v = 32'h8000_0001;
            endcase
         end
         default: v = $urandom_range(0, 1) ? 0 : radix - 1;
      endcase
      return flip ? -v : v;
   endfunction

   initial begin
      logic [ALPHABET_BITS-1:0] symbols;
      alphabet_kind_type        kind;
      int                       radix;
      int                       batch;
      int                       pause_at;
      int                       random_done;

      req_if.valid <= 1'b0;
      req_if.value <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      reset        <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers still at reset: radix 0, nothing comes out
      send_value(32'd5);
      wait_idle(DRAIN_CYCLES);

      // decimal with ASCII digits
      csr_write(REG_UNMAPPED, {$urandom, $urandom});
      symbols = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < 10; i++) symbols[i*8 +: 8] = SYMBOL_BITS'(8'h30 + i);
      configure(10, symbols);
      send_value(32'd0);
      send_value(32'd1);
      send_value(-32'sd1);
      send_value(32'd10);
      send_value(-32'sd10);
      send_value(32'h7fff_ffff);
      send_value(32'h8000_0000);
      send_value(32'd123456789);
      wait_idle(DRAIN_CYCLES);

      // hex using 00, 11 .. ff, so a zero byte is a symbol
      for (int i = 0; i < MAX_SYMBOLS; i++) symbols[i*8 +: 8] = SYMBOL_BITS'(8'h11 * i);
      configure(16, symbols);
      send_value(32'h8000_0000);
      send_value(32'h7fff_ffff);
      send_value(32'hffff_ffff);
      send_value(32'hdead_beef);
      wait_idle(DRAIN_CYCLES);

      // binary; unused slots full of signs and repeats
      symbols = {8{CHAR_MINUS, CHAR_PLUS}};
      symbols[15:0] = 16'h00ff;
      configure(2, symbols);
      send_value(32'h8000_0000);   // sign plus 32 digits
      send_value(32'h7fff_ffff);
      send_value(32'hffff_ffff);
      send_value(32'd0);
      wait_idle(DRAIN_CYCLES);

      // rejected alphabets: radix 1, 17, 31, then sign symbols and a repeat
      for (int k = 0; k < 6; k++) begin
         radix = (k == 0) ? 1 : (k == 1) ? 17 : (k == 2) ? 31 : MAX_SYMBOLS;
         kind  = (k < 3) ? ALPHA_BAD_RADIX : alphabet_kind_type'(k - 1);
         configure(radix, make_alphabet(MAX_SYMBOLS, kind));
         send_value($urandom);
         wait_idle(DRAIN_CYCLES);
      end

      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) != 0) kind = ALPHA_GOOD;
         else kind = alphabet_kind_type'($urandom_range(1, 4));
         if (kind == ALPHA_BAD_RADIX) begin
            radix = $urandom_range(0, 16);
            if (radix >= 2) radix = radix + 15;
            symbols = make_alphabet(MAX_SYMBOLS, kind);
         end else begin
            case ($urandom_range(0, 3))
               0:       radix = 2;
               1:       radix = MAX_BASE;
               default: radix = $urandom_range(2, MAX_BASE);
            endcase
            symbols = make_alphabet(radix, kind);
         end
         configure(radix, symbols);
         sender_steady = ($urandom_range(0, 3) == 0);
         batch    = (kind == ALPHA_GOOD) ? $urandom_range(20, 50) : 3;
         pause_at = $urandom_range(1, batch - 1);
         for (int i = 0; i < batch; i++) begin
            if (i == pause_at) wait_idle(0);
            send_value(random_value(radix));
         end
         if (kind == ALPHA_GOOD) random_done += batch;
         wait_idle(DRAIN_CYCLES);
      end

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
